### sv/hsc_pkg.sv
package hsc_pkg;

   localparam int BUCKETS  = 64;
   localparam int WAYS     = 4;
   localparam int KEY_BITS = 31;

   // Port widths of the request fields
   localparam int CMD_W    = 2;
   localparam int KEY_W    = 31;

   localparam int BKT_W    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int MOD_W    = (KEY_BITS > BKT_W) ? KEY_BITS + 1 : BKT_W + 1;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

   typedef logic [KEY_BITS-1:0] key_type;
   typedef logic [BKT_W-1:0]    bkt_type;

   // One bucket row: valid marks and the keys of all ways
   typedef struct packed {
      logic [WAYS-1:0]              valid;
      logic [WAYS-1:0][KEY_BITS-1:0] keys;
   } row_type;

   localparam int ROW_W = $bits(row_type);

   typedef struct packed {
      logic found;
      logic status;
      logic wr_en;
   } upd_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   // BUCKETS is a power of two, so this reduces to a mask
   function automatic bkt_type bucket_of(input key_type key);
      logic [MOD_W-1:0] rem;
      rem = MOD_W'(key) % MOD_W'(BUCKETS);
      return BKT_W'(rem);
   endfunction

endpackage

### sv/hsc_ram.sv
module hsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/hsc_row_update.sv
module hsc_row_update (
   input  hsc_pkg::row_type                row_in,
   input  logic [hsc_pkg::CMD_W-1:0]       cmd,
   input  hsc_pkg::key_type                key,
   output hsc_pkg::row_type                row_out,
   output hsc_pkg::upd_type                upd
);
   import hsc_pkg::*;

   logic [WAYS-1:0] hit;
   logic [WAYS-1:0] free_sel;
   logic            found;
   logic            has_free;

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         hit[w] = row_in.valid[w] && (row_in.keys[w] == key);
      end
   end

   // Pick the lowest free way
   always_comb begin
      free_sel = '0;
      has_free = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
         if (!row_in.valid[w] && !has_free) begin
            free_sel[w] = 1'b1;
            has_free    = 1'b1;
         end
      end
   end

   assign found = |hit;

   always_comb begin
      row_out    = row_in;
      upd.found  = found;
      upd.status = 1'b0;
      upd.wr_en  = 1'b0;
      case (cmd)
         CMD_INSERT: begin
            if (!found) begin
               if (has_free) begin
                  for (int w = 0; w < WAYS; w++) begin
                     if (free_sel[w]) begin
                        row_out.keys[w] = key;
                     end
                  end
                  row_out.valid = row_in.valid | free_sel;
                  upd.wr_en     = 1'b1;
               end else begin
                  upd.status = 1'b1;
               end
            end
         end
         CMD_REMOVE: begin
            if (found) begin
               row_out.valid = row_in.valid & ~hit;
               upd.wr_en     = 1'b1;
            end
         end
         default: begin
            // lookup, and the unused code acts as one
         end
      endcase
   end

endmodule

### sv/hash_set_chained_buckets.sv
// Hash set of keys in BUCKETS buckets of WAYS slots each; bucket = key mod BUCKETS.
// Request channel (req_valid/req_ready): req_cmd is insert, remove or lookup,
// req_key the key. Result channel (rsp_valid/rsp_ready): exactly one beat per
// request, rsp_found = key was present before the request, rsp_status = 1 when
// an insert found its bucket full and was dropped.
// Each request is a read-modify-write of one bucket row in a single-port-read
// RAM with a registered read: the row is read in the accept cycle, compared in
// the next, and written back in the cycle that moves the result into the output
// register, which a held result can delay. No new request is taken until the
// current one has finished.
// The output register lets the next request be taken while a result waits.
// When the receiver stalls with a result held and another one finished, the
// block holds in its compare cycle and takes no further request until the
// held beat leaves.
// Reset clears the per-row valid flags in flip-flops at once, so the set is
// empty and requests are taken from the first cycle after reset; no clearing
// pass runs.
module hash_set_chained_buckets (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [hsc_pkg::CMD_W-1:0]   req_cmd,
   input  logic [hsc_pkg::KEY_W-1:0]   req_key,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_found,
   output logic                        rsp_status
);
   import hsc_pkg::*;

   state_type          state_ff, state_in;
   logic [CMD_W-1:0]   cmd_ff;
   key_type            key_ff;
   bkt_type            bkt_ff;
   logic [BUCKETS-1:0] row_init_ff, row_init_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_status_ff;

   key_type  req_key_m;
   bkt_type  req_bkt;
   logic     accept;
   logic     finish;
   logic     ram_rd_en;
   logic [ROW_W-1:0] ram_rd_data;
   row_type  row_rd, row_cur, row_new;
   upd_type  upd;
   logic     ram_wr_en;

   assign req_key_m = KEY_BITS'(req_key);
   assign req_bkt   = bucket_of(req_key_m);
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign ram_rd_en = accept;
   assign finish    = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign ram_wr_en = finish && upd.wr_en;

   hsc_ram #(
      .WIDTH(ROW_W),
      .DEPTH(BUCKETS)
   ) u_row_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(bkt_ff),
      .wr_data(row_new),
      .rd_en  (ram_rd_en),
      .rd_addr(req_bkt),
      .rd_data(ram_rd_data)
   );

   // A row never written reads as empty
   always_comb begin
      row_rd  = row_type'(ram_rd_data);
      row_cur = row_rd;
      if (!row_init_ff[bkt_ff]) begin
         row_cur.valid = '0;
      end
   end

   hsc_row_update u_update (
      .row_in (row_cur),
      .cmd    (cmd_ff),
      .key    (key_ff),
      .row_out(row_new),
      .upd    (upd)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (finish) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      row_init_in = row_init_ff;
      if (ram_wr_en) begin
         row_init_in[bkt_ff] = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_init_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_init_ff  <= row_init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the request for the compare cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_cmd;
         key_ff <= req_key_m;
         bkt_ff <= req_bkt;
      end
      if (finish) begin
         rsp_found_ff  <= upd.found;
         rsp_status_ff <= upd.status;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_status = rsp_status_ff;

   a_wr_in_exec: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == S_EXEC))
      else $error("row write outside compare cycle");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC))
      else $error("accepted beat did not enter compare cycle");

   a_finish_rsp: assert property (@(posedge clock) disable iff (reset)
      finish |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("finished request produced no result beat");

   a_drop_absent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> !rsp_found_ff)
      else $error("dropped insert reported key as present");

endmodule

### bench/set_membership_checker.sv
`timescale 1ns / 100ps

module set_membership_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [hsc_pkg::CMD_W-1:0] req_cmd,
   input  logic [hsc_pkg::KEY_W-1:0] req_key,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic                      rsp_found,
   input  logic                      rsp_status,
   output int                        fail_count,
   output int                        answers_pending,
   output int                        hit_count,
   output int                        full_count
);
   import hsc_pkg::*;

   typedef struct packed {
      logic found;
      logic status;
   } membership_type;

   key_type         stored_key [BUCKETS][WAYS];
   logic [WAYS-1:0] way_used [BUCKETS];
   membership_type  pending_answers [$];

   int mismatches = 0;
   int hits = 0;
   int drops = 0;

   assign fail_count = mismatches;
   assign hit_count  = hits;
   assign full_count = drops;

   // Apply one request to the shadow set and return the answer it should get.
   function automatic membership_type apply_request(input logic [CMD_W-1:0] cmd,
                                                    input logic [KEY_W-1:0] raw_key);
      key_type        k;
      int             b;
      int             hit_way;
      int             free_way;
      membership_type ans;
      k = key_type'(raw_key);
      b = k % BUCKETS;
      hit_way = -1;
      free_way = -1;
      for (int w = 0; w < WAYS; w++) begin
         if (way_used[b][w] && stored_key[b][w] == k && hit_way < 0)
            hit_way = w;
         if (!way_used[b][w] && free_way < 0)
            free_way = w;
      end
      ans.found = (hit_way >= 0);
      ans.status = 1'b0;
      if (cmd == CMD_INSERT && hit_way < 0) begin
         if (free_way >= 0) begin
            stored_key[b][free_way] = k;
            way_used[b][free_way] = 1'b1;
         end else begin
            ans.status = 1'b1;
         end
      end else if (cmd == CMD_REMOVE && hit_way >= 0) begin
         way_used[b][hit_way] = 1'b0;
      end
      return ans;
   endfunction

   always @(posedge clock) begin
      membership_type due;
      if (reset) begin
         for (int b = 0; b < BUCKETS; b++)
            way_used[b] = '0;
         pending_answers.delete();
         answers_pending <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_answers.size() == 0) begin
               $error("result beat with nothing outstanding: found %0b status %0b",
                      rsp_found, rsp_status);
               mismatches++;
            end else begin
               due = pending_answers.pop_front();
               if (rsp_found !== due.found) begin
                  $error("rsp_found mismatch: expected %0b, actual %0b",
                         due.found, rsp_found);
                  mismatches++;
               end
               if (rsp_status !== due.status) begin
                  $error("rsp_status mismatch: expected %0b, actual %0b",
                         due.status, rsp_status);
                  mismatches++;
               end
               if (due.found) hits++;
               if (due.status) drops++;
            end
         end
         if (req_valid && req_ready)
            pending_answers.push_back(apply_request(req_cmd, req_key));
         answers_pending <= pending_answers.size();
      end
   end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
   import hsc_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES = 6;
   localparam int PHASE_ITEMS = 150;
   localparam int LONG_HOLD = 300;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [CMD_W-1:0] req_cmd = CMD_INSERT;
   logic [KEY_W-1:0] req_key = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic             rsp_found;
   logic             rsp_status;
   logic             hold_go = 1'b0;

   int fail_count;
   int answers_pending;
   int hit_count;
   int full_count;
   int cycles = 0;
   int sent_by_cmd [4] = '{0, 0, 0, 0};

   logic [KEY_W-1:0] hot_base;
   int               hot_bkt [4];

   always #10 clock = ~clock;

   hash_set_chained_buckets dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_cmd    (req_cmd),
      .req_key    (req_key),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_found  (rsp_found),
      .rsp_status (rsp_status)
   );

   set_membership_checker chk (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_status      (rsp_status),
      .fail_count      (fail_count),
      .answers_pending (answers_pending),
      .hit_count       (hit_count),
      .full_count      (full_count)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Offer one request and hold it until the block takes it.
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key);
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_key   <= key;
      sent_by_cmd[cmd]++;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait until every outstanding answer has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (answers_pending != 0) @(posedge clock);
   endtask

   function automatic logic [CMD_W-1:0] pick_cmd();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return CMD_INSERT;
      if (r < 70) return CMD_REMOVE;
      if (r < 95) return CMD_LOOKUP;
      return CMD_UNUSED;
   endfunction

   // Keys crowded into a few buckets so chains fill, repeat and empty again.
   function automatic logic [KEY_W-1:0] hot_key();
      logic [KEY_W-1:0] upper;
      upper = hot_base ^ KEY_W'($urandom_range(0, 7));
      return KEY_W'(upper * BUCKETS + hot_bkt[$urandom_range(0, 3)]);
   endfunction

   // Receiver: own ready pattern, with its mode redrawn at random on a tick counter, plus one long hold.
   initial begin
      int  mode;
      int  tick;
      bit  held;
      mode = 0;
      tick = 0;
      held = 0;
      forever begin
         @(posedge clock);
         if (hold_go && !held) begin
            held = 1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            tick++;
            if (tick % 64 == 0) mode = $urandom_range(0, 3);
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= (tick % 3 == 0);
            endcase
         end
      end
   end

   initial begin
      int sent;
      int burst;
      int gap;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty set, duplicate insert
      send_request(CMD_LOOKUP, 31'd0);
      send_request(CMD_INSERT, 31'd0);
      send_request(CMD_INSERT, 31'd0);
      send_request(CMD_LOOKUP, 31'd0);
      // fill bucket 5, overflow it, free a middle way and refill it
      send_request(CMD_INSERT, 31'd5);
      send_request(CMD_INSERT, 31'd69);
      send_request(CMD_INSERT, 31'd133);
      send_request(CMD_INSERT, 31'd197);
      send_request(CMD_INSERT, 31'd261);
      send_request(CMD_REMOVE, 31'd69);
      send_request(CMD_INSERT, 31'd261);
      send_request(CMD_LOOKUP, 31'd69);
      send_request(CMD_LOOKUP, 31'd261);
      // remove of absent key, unused code as lookup
      send_request(CMD_REMOVE, 31'd1000);
      send_request(CMD_UNUSED, 31'd261);
      send_request(CMD_UNUSED, 31'd7);
      // largest key
      send_request(CMD_INSERT, 31'h7fff_ffff);
      send_request(CMD_LOOKUP, 31'h7fff_ffff);
      send_request(CMD_REMOVE, 31'h7fff_ffff);
      send_request(CMD_LOOKUP, 31'h7fff_ffff);
      send_request(CMD_REMOVE, 31'd0);
      drain();

      for (int phase = 0; phase < PHASES; phase++) begin
         hot_base = KEY_W'($urandom);
         for (int i = 0; i < 4; i++)
            hot_bkt[i] = $urandom_range(0, BUCKETS - 1);
         // receiver holds off for a long stretch while requests keep coming
         if (phase == 1) hold_go <= 1'b1;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            burst = $urandom_range(1, 16);
            for (int i = 0; i < burst && sent < PHASE_ITEMS; i++) begin
               if ($urandom_range(0, 3) != 0)
                  send_request(pick_cmd(), hot_key());
               else
                  send_request(CMD_W'($urandom_range(0, 3)), KEY_W'($urandom));
               sent++;
            end
            // phase 2 runs back to back without sender gaps
            gap = (phase == 2) ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         drain();
      end

      repeat (20) @(posedge clock);
      $display("Covered %0d inserts, %0d removes, %0d lookups, %0d unused-code requests",
               sent_by_cmd[CMD_INSERT], sent_by_cmd[CMD_REMOVE],
               sent_by_cmd[CMD_LOOKUP], sent_by_cmd[CMD_UNUSED]);
      $display("Keys found present %0d times, %0d inserts dropped on full buckets",
               hit_count, full_count);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
